### design/wsk_pkg.sv
// Package for the waypoint segment kinematics block: widths, constants,
// controller states and the command/status structs. No dependencies.
package wsk_pkg;

    localparam int COORD_BITS = 32;
    localparam int SPEED_BITS = 20;
    // Difference of two coordinates, one bit wider.
    localparam int DIFF_BITS  = COORD_BITS + 1;
    // Sum of three squared differences.
    localparam int SQ_BITS    = 2 * DIFF_BITS + 2;
    // Root width: half the square width, rounded up.
    localparam int ROOT_BITS  = (SQ_BITS + 1) / 2;
    localparam int SUM_BITS   = SPEED_BITS + 1;
    // Numerator 2000*D; 2000 < 2^11.
    localparam int NUM_BITS   = ROOT_BITS + 11;
    // Rate numerators: magnitude times 1000; 1000 < 2^10.
    localparam int RNUM_BITS  = DIFF_BITS + 10;
    // Divider width covers the widest numerator.
    localparam int DIV_BITS   = (NUM_BITS > RNUM_BITS) ? NUM_BITS : RNUM_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);
    localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS + 1);

    localparam logic [10:0] K_TIME = 11'd2000;
    localparam logic [9:0]  K_RATE = 10'd1000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ,
        ST_ROOT,
        ST_TDIV,
        ST_CDIV,
        ST_ADIV,
        ST_OUT
    } t_state;

    // Division operand select.
    typedef enum logic [1:0] {
        DV_TIME,
        DV_CLIMB,
        DV_ACCEL
    } t_div_sel;

    typedef struct packed {
        logic     load;       // capture input request
        logic     square;     // register difference magnitudes, signs and the speed sum
        logic     root_start;
        logic     root_step;
        logic     div_start;
        logic     div_step;
        t_div_sel div_sel;
        logic     store_time;
        logic     store_climb;
        logic     store_accel;
        logic     commit;     // new waypoint becomes the stored one
    } t_cmd;

    typedef struct packed {
        logic root_done;
        logic div_done;
        logic time_zero;      // sum zero or quotient zero
    } t_status;

endpackage

### design/waypoint_segment_kinematics.sv
// Top level of the waypoint segment kinematics block: joins controller
// and datapath. Uses wsk_pkg, wsk_ctrl and wsk_datapath.
//
//  channel  | dir | fields (low bit first)
//  s_axis   | in  | height_cm, north_cm, east_cm, speed_cms
//  m_axis   | out | travel_time_ms, climb_rate_cms, accel_cms2; tuser no_time
//
// A result is offered once its request has passed three capture steps, the
// bit-serial root and three divisions (a load, then one step per quotient bit)
// through one shared restoring divider and one store step. With a zero speed
// sum or zero time the rate divisions are skipped.
// The next request can be taken in the cycle after the result leaves.
// Reset is synchronous and active low and clears the stored waypoint.
// A stalled result holds; no new request is taken until it is delivered.
module waypoint_segment_kinematics (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,  // height_cm, north_cm, east_cm, speed_cms
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,  // travel_time_ms, climb_rate_cms, accel_cms2
    output logic         m_axis_tuser   // no_time
);
    wsk_pkg::t_cmd    w_cmd;
    wsk_pkg::t_status w_status;
    logic [31:0] w_t, w_c, w_a;

    wsk_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    wsk_datapath u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .o_status(w_status),
        .i_height_cm(s_axis_tdata[31:0]), .i_north_cm(s_axis_tdata[63:32]),
        .i_east_cm(s_axis_tdata[95:64]), .i_speed_cms(s_axis_tdata[115:96]),
        .i_rst_n(i_rst_n),
        .o_travel_time_ms(w_t), .o_climb_rate_cms(w_c), .o_accel_cms2(w_a),
        .o_no_time(m_axis_tuser)
    );

    assign m_axis_tdata = {w_a, w_c, w_t};
endmodule

### design/wsk_datapath.sv
// Datapath of the waypoint segment kinematics block: differences, squares,
// bit-serial square root and shared restoring divider. Uses wsk_pkg.
module wsk_datapath (
    input  logic                                i_clk,
    input  wsk_pkg::t_cmd                       i_cmd,
    output wsk_pkg::t_status                    o_status,
    input  logic signed [wsk_pkg::COORD_BITS-1:0] i_height_cm,
    input  logic signed [wsk_pkg::COORD_BITS-1:0] i_north_cm,
    input  logic signed [wsk_pkg::COORD_BITS-1:0] i_east_cm,
    input  logic [wsk_pkg::SPEED_BITS-1:0]      i_speed_cms,
    input  logic                                i_rst_n,
    output logic [31:0]                         o_travel_time_ms,
    output logic signed [31:0]                  o_climb_rate_cms,
    output logic signed [31:0]                  o_accel_cms2,
    output logic                                o_no_time
);
    localparam int CB = wsk_pkg::COORD_BITS;
    localparam int DB = wsk_pkg::DIFF_BITS;
    localparam int SB = wsk_pkg::SQ_BITS;
    localparam int RB = wsk_pkg::ROOT_BITS;
    localparam int VB = wsk_pkg::SPEED_BITS;
    localparam int QB = wsk_pkg::DIV_BITS;
    localparam int UB = wsk_pkg::SUM_BITS;

    // Stored waypoint.
    logic signed [CB-1:0] r_ph, r_pn, r_pe;
    logic [VB-1:0]        r_pv;
    // New waypoint.
    logic signed [CB-1:0] r_h, r_n, r_e;
    logic [VB-1:0]        r_v;
    // Magnitudes and signs.
    logic [DB-1:0] r_mh, r_mn, r_me;
    logic [VB-1:0] r_mv;
    logic          r_nh, r_nv;
    logic [UB-1:0] r_sum;
    logic [SB-1:0] r_sq;
    // Square root state.
    logic [RB-1:0] r_root;
    logic [SB+1:0] r_rem;
    logic [SB-1:0] r_rad;
    logic [wsk_pkg::ROOT_CNT_BITS-1:0] r_rcnt;
    // Divider state.
    logic [QB-1:0]  r_num, r_quo;
    logic [QB-1:0]  r_den;
    logic [QB:0]    r_drem;
    logic [wsk_pkg::DIV_CNT_BITS-1:0] r_dcnt;
    logic [QB-1:0]  r_t;

    logic signed [DB-1:0] w_dh, w_dn, w_de;
    logic [2*DB-1:0] w_p0, w_p1, w_p2;
    logic [SB+1:0]   w_trial;
    logic [SB+1:0]   w_rem_sh;
    logic [QB:0]     w_dsh;
    logic [QB-1:0]   w_numsel;
    logic [QB-1:0]   w_densel;
    logic            w_rneg;
    logic [31:0]     w_rate;

    assign w_dh = DB'(r_h) - DB'(r_ph);
    assign w_dn = DB'(r_n) - DB'(r_pn);
    assign w_de = DB'(r_e) - DB'(r_pe);
    assign w_p0 = r_mh * r_mh;
    assign w_p1 = r_mn * r_mn;
    assign w_p2 = r_me * r_me;

    // Root: two radicand bits per step, classic digit-by-digit.
    assign w_rem_sh = {r_rem[SB-1:0], r_rad[SB-1 -: 2]};
    assign w_trial  = (SB+2)'({r_root, 2'b01});

    // Divider: one quotient bit per step.
    assign w_dsh = {r_drem[QB-1:0], r_num[QB-1]};

    // The time quotient is the rate divisor; it is taken straight from the
    // divider in the cycle it is stored.
    always_comb begin
        w_numsel = '0;
        w_densel = i_cmd.store_time ? r_quo : r_t;
        case (i_cmd.div_sel)
            wsk_pkg::DV_TIME: begin
                w_numsel = QB'(r_root) * QB'(wsk_pkg::K_TIME);
                w_densel = QB'(r_sum);
            end
            wsk_pkg::DV_CLIMB: w_numsel = QB'(r_mh) * QB'(wsk_pkg::K_RATE);
            wsk_pkg::DV_ACCEL: w_numsel = QB'(r_mv) * QB'(wsk_pkg::K_RATE);
            default: w_numsel = '0;
        endcase
    end

    // Rate saturation from the quotient.
    always_comb begin
        if (w_rneg) begin
            if (r_quo >= QB'(64'h8000_0000)) w_rate = 32'h8000_0000;
            else                              w_rate = 32'd0 - r_quo[31:0];
        end else begin
            if (r_quo > QB'(64'h7FFF_FFFF))  w_rate = 32'h7FFF_FFFF;
            else                              w_rate = r_quo[31:0];
        end
    end
    assign w_rneg = (i_cmd.store_climb) ? r_nh : r_nv;

    // Stored waypoint, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= '0; r_pn <= '0; r_pe <= '0; r_pv <= '0;
        end else if (i_cmd.commit) begin
            r_ph <= r_h; r_pn <= r_n; r_pe <= r_e; r_pv <= r_v;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_h <= i_height_cm; r_n <= i_north_cm;
            r_e <= i_east_cm;   r_v <= i_speed_cms;
        end
        if (i_cmd.square) begin
            // Differences are computed from the captured request.
            r_mh  <= w_dh[DB-1] ? DB'(-w_dh) : DB'(w_dh);
            r_nh  <= w_dh[DB-1];
            r_mn  <= w_dn[DB-1] ? DB'(-w_dn) : DB'(w_dn);
            r_me  <= w_de[DB-1] ? DB'(-w_de) : DB'(w_de);
            r_nv  <= r_v < r_pv;
            r_mv  <= (r_v < r_pv) ? r_pv - r_v : r_v - r_pv;
            r_sum <= UB'(r_pv) + UB'(r_v);
        end
        if (i_cmd.root_start) begin
            r_sq   <= SB'(w_p0) + SB'(w_p1) + SB'(w_p2);
        end
        if (i_cmd.root_step && r_rcnt == '0) begin
            r_rad  <= r_sq;
            r_rem  <= '0;
            r_root <= '0;
            r_rcnt <= wsk_pkg::ROOT_CNT_BITS'(RB);
        end else if (i_cmd.root_step) begin
            r_rad <= r_rad << 2;
            r_rcnt <= r_rcnt - 1'b1;
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[RB-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[RB-2:0], 1'b0};
            end
        end
        if (i_cmd.root_start) r_rcnt <= '0;
        if (i_cmd.div_start) begin
            r_num  <= w_numsel;
            r_den  <= w_densel;
            r_drem <= '0;
            r_quo  <= '0;
            r_dcnt <= wsk_pkg::DIV_CNT_BITS'(QB);
        end else if (i_cmd.div_step) begin
            r_num  <= r_num << 1;
            r_dcnt <= r_dcnt - 1'b1;
            if (w_dsh >= {1'b0, r_den}) begin
                r_drem <= w_dsh - {1'b0, r_den};
                r_quo  <= {r_quo[QB-2:0], 1'b1};
            end else begin
                r_drem <= w_dsh;
                r_quo  <= {r_quo[QB-2:0], 1'b0};
            end
        end
        if (i_cmd.store_time) r_t <= r_quo;
        if (i_cmd.load) begin
            o_travel_time_ms <= '0; o_climb_rate_cms <= '0;
            o_accel_cms2 <= '0; o_no_time <= 1'b1;
        end
        if (i_cmd.store_time && r_sum != '0 && r_quo != '0) begin
            o_travel_time_ms <= (r_quo > QB'(64'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                             : r_quo[31:0];
            o_no_time <= 1'b0;
        end
        if (i_cmd.store_climb) o_climb_rate_cms <= w_rate;
        if (i_cmd.store_accel) o_accel_cms2 <= w_rate;
    end

    assign o_status.root_done = (r_rcnt == 1) && i_cmd.root_step;
    assign o_status.div_done  = (r_dcnt == 1) && i_cmd.div_step;
    assign o_status.time_zero = (r_sum == '0) || (r_quo == '0);
endmodule

### design/wsk_ctrl.sv
// Controller of the waypoint segment kinematics block: sequences capture,
// root and three divisions and runs the handshake. Uses wsk_pkg.
module wsk_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  wsk_pkg::t_status i_status,
    output wsk_pkg::t_cmd    o_cmd
);
    wsk_pkg::t_state r_state, n_state;
    logic            r_rootgo, n_rootgo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wsk_pkg::ST_IDLE;
            r_rootgo <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rootgo <= n_rootgo;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_rootgo    = 1'b0;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            wsk_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = wsk_pkg::ST_DIFF;
                end
            end
            wsk_pkg::ST_DIFF: begin
                o_cmd.square = 1'b1;
                n_state      = wsk_pkg::ST_SQ;
            end
            wsk_pkg::ST_SQ: begin
                o_cmd.root_start = 1'b1;
                n_state          = wsk_pkg::ST_ROOT;
            end
            wsk_pkg::ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_rootgo        = 1'b1;
                if (r_rootgo && i_status.root_done) begin
                    o_cmd.div_start = 1'b0;
                    n_state = wsk_pkg::ST_TDIV;
                    n_rootgo = 1'b0;
                end
            end
            wsk_pkg::ST_TDIV: begin
                o_cmd.div_sel = wsk_pkg::DV_TIME;
                if (!r_rootgo) begin
                    o_cmd.div_start = 1'b1;
                    n_rootgo = 1'b1;
                end else if (i_status.div_done) begin
                    o_cmd.div_step = 1'b1;
                    n_state = wsk_pkg::ST_CDIV;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_rootgo = 1'b1;
                end
            end
            wsk_pkg::ST_CDIV: begin
                o_cmd.div_sel = wsk_pkg::DV_CLIMB;
                if (!r_rootgo) begin
                    // Quotient of the time division is final here.
                    o_cmd.store_time = 1'b1;
                    if (i_status.time_zero) begin
                        n_state = wsk_pkg::ST_OUT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_rootgo = 1'b1;
                    end
                end else if (i_status.div_done) begin
                    o_cmd.div_step = 1'b1;
                    n_state = wsk_pkg::ST_ADIV;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_rootgo = 1'b1;
                end
            end
            wsk_pkg::ST_ADIV: begin
                o_cmd.div_sel = wsk_pkg::DV_ACCEL;
                if (!r_rootgo) begin
                    o_cmd.store_climb = 1'b1;
                    o_cmd.div_start   = 1'b1;
                    n_rootgo = 1'b1;
                end else if (i_status.div_done) begin
                    o_cmd.div_step = 1'b1;
                    n_rootgo = 1'b1;
                    n_state = wsk_pkg::ST_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_rootgo = 1'b1;
                end
            end
            wsk_pkg::ST_OUT: begin
                if (r_rootgo) begin
                    o_cmd.store_accel = 1'b1;
                end else begin
                    o_out_valid = 1'b1;
                    if (i_out_ready) begin
                        o_cmd.commit = 1'b1;
                        n_state = wsk_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = wsk_pkg::ST_IDLE;
        endcase
    end
endmodule

### design/wsk_checker.sv
// Port checker for the waypoint segment kinematics block, bound to the top
// level. Depends only on the top level's ports.
module wsk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    // Never ready for input while a result is offered.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready during result");
    // A request is never followed by a result in the next cycle.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result too early");
    // No-time results carry zero data.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("no_time with data");
    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped");
endmodule

bind waypoint_segment_kinematics wsk_checker u_wsk_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
